[rtl/vwtp_pkg.sv]
package vwtp_pkg;

	localparam int TOKEN_W       = 16;
	localparam int WIDTH_W       = 5;
	localparam int BYTE_W        = 8;
	localparam int STATUS_W      = 2;
	localparam int CAP_W         = 32;
	localparam int PEND_W        = 7;
	localparam int MAX_WIDTH_DEF = 16;

	localparam logic [CAP_W-1:0] CAP_RESET = '1;

	localparam logic [STATUS_W-1:0] STATUS_WRITTEN   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_WIDTH = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic load;   // capture a token beat
		logic emit;   // move one result into the output register
	} vwtp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic has_work;  // a byte or an error result is ready to go out
		logic last;      // the next result ends the run of this token
		logic out_free;  // output register can take a result this cycle
	} vwtp_sts_t;

endpackage

[rtl/vwtp_ifs.sv]
interface vwtp_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [vwtp_pkg::CAP_W-1:0]    dest_capacity;

	modport source (output valid, output dest_capacity, input ready);
	modport sink   (input valid, input dest_capacity, output ready);
endinterface

interface vwtp_tok_if;
	logic                          valid;
	logic                          ready;
	logic [vwtp_pkg::TOKEN_W-1:0]  token_value;
	logic [vwtp_pkg::WIDTH_W-1:0]  token_width;

	modport source (output valid, output token_value, output token_width, input ready);
	modport sink   (input valid, input token_value, input token_width, output ready);
endinterface

interface vwtp_byte_if;
	logic                          valid;
	logic                          ready;
	logic [vwtp_pkg::BYTE_W-1:0]   out_byte;
	logic [vwtp_pkg::STATUS_W-1:0] status;
	logic                          last_of_run;

	modport source (output valid, output out_byte, output status, output last_of_run,
		input ready);
	modport sink   (input valid, input out_byte, input status, input last_of_run,
		output ready);
endinterface

[rtl/vwtp_ctrl.sv]
module vwtp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  vwtp_pkg::vwtp_sts_t sts,
	output vwtp_pkg::vwtp_cmd_t cmd
);
	import vwtp_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic state_q;
	logic state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!sts.has_work) begin
					state_d = ST_IDLE;   // token left only pending bits
				end else if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_idle_no_work: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !sts.has_work)
		else $error("work left over while idle");

	a_emit_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free && sts.has_work)
		else $error("emit without a free output slot");

	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_EMIT && $past(state_q) == ST_IDLE)
		else $error("load outside idle");

endmodule

[rtl/vwtp_dp.sv]
module vwtp_dp #(
	parameter int MAX_WIDTH = vwtp_pkg::MAX_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  vwtp_pkg::vwtp_cmd_t             cmd,
	output vwtp_pkg::vwtp_sts_t             sts,
	input  logic                            cfg_we,
	input  logic [vwtp_pkg::CAP_W-1:0]      cfg_data,
	input  logic [vwtp_pkg::TOKEN_W-1:0]    token_value,
	input  logic [vwtp_pkg::WIDTH_W-1:0]    token_width,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [vwtp_pkg::BYTE_W-1:0]     out_byte,
	output logic [vwtp_pkg::STATUS_W-1:0]   status,
	output logic                            last_of_run
);
	import vwtp_pkg::*;

	localparam int ACC_W = PEND_W + MAX_WIDTH;
	localparam int TOT_W = $clog2(ACC_W + 1);
	localparam int EXT_W = 32;

	logic [ACC_W-1:0]    acc_q;
	logic [TOT_W-1:0]    total_q;
	logic                bad_q;
	logic [CAP_W-1:0]    cap_q;
	logic [CAP_W-1:0]    written_q;
	logic                out_valid_q;
	logic [BYTE_W-1:0]   out_byte_q;
	logic [STATUS_W-1:0] status_q;
	logic                last_q;

	logic                width_bad;
	logic [TOKEN_W-1:0]  tok_masked;
	logic [PEND_W-1:0]   pend;
	logic [EXT_W-1:0]    acc_new;
	logic [TOT_W-1:0]    total_new;
	logic [ACC_W-1:0]    acc_shr;
	logic [TOT_W-1:0]    total_dec;
	logic                room;

	assign width_bad  = (token_width == '0) || (token_width > WIDTH_W'(MAX_WIDTH));
	assign tok_masked = token_value & ~({TOKEN_W{1'b1}} << token_width);
	// idle leaves total_q below 8; bits above it are stale
	assign pend       = acc_q[PEND_W-1:0] & ~({PEND_W{1'b1}} << total_q[2:0]);
	assign acc_new    = (EXT_W'(pend) << token_width) | EXT_W'(tok_masked);
	assign total_new  = total_q + TOT_W'(token_width);

	assign total_dec  = total_q - TOT_W'(BYTE_W);
	assign acc_shr    = acc_q >> total_dec;
	assign room       = written_q < cap_q;

	assign sts.has_work = bad_q || (total_q >= TOT_W'(BYTE_W));
	assign sts.last     = bad_q || (total_dec < TOT_W'(BYTE_W));
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			total_q   <= '0;
			bad_q     <= 1'b0;
			cap_q     <= CAP_RESET;
			written_q <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (cmd.load) begin
				if (width_bad) begin
					bad_q <= 1'b1;
				end else begin
					acc_q   <= acc_new[ACC_W-1:0];
					total_q <= total_new;
				end
			end else if (cmd.emit) begin
				if (bad_q) begin
					bad_q <= 1'b0;
				end else begin
					total_q <= total_dec;
					if (room) begin
						written_q <= written_q + CAP_W'(1);
					end
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			last_q <= sts.last;
			if (bad_q) begin
				out_byte_q <= '0;
				status_q   <= STATUS_BAD_WIDTH;
			end else begin
				out_byte_q <= acc_shr[BYTE_W-1:0];
				status_q   <= room ? STATUS_WRITTEN : STATUS_FULL;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign status      = status_q;
	assign last_of_run = last_q;

	a_bad_keeps_pending: assert property (@(posedge clk) disable iff (!arst_n)
		bad_q |-> total_q < TOT_W'(BYTE_W))
		else $error("error result pending with bytes still queued");

	a_emit_fills_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q)
		else $error("emitted result not in output register");

endmodule

[rtl/variable_width_token_packer.sv]
// Variable-width token packer, MSB first.
//
// tok_in   : token beats (token_value, token_width). Only the low token_width
//            bits of token_value are used; a width of 0 or above MAX_WIDTH
//            yields one error beat (status 2, last_of_run 1) and no state change.
// byte_out : one beat per completed byte, oldest first; last_of_run marks the
//            final beat caused by a token. Status 1 means the destination
//            capacity was used up and the byte was dropped (still shown).
// cfg      : writes dest_capacity, always ready; write only while idle.
//
// Timing: a token beat is taken while idle, then its n result beats leave
// one per cycle from the output register while the receiver is ready (n is
// 0..2 at the default width). With a single output register, the next token
// is taken once the last result of the current one is registered, even while
// that result still waits downstream. A byte is visible on byte_out in the
// cycle after it is formed.
// Reset clears pending bits and the byte count and sets the capacity to all
// ones. A stalled receiver holds the output register and pauses emission.
module variable_width_token_packer #(
	parameter int MAX_WIDTH = vwtp_pkg::MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	vwtp_cfg_if.sink    cfg,
	vwtp_tok_if.sink    tok_in,
	vwtp_byte_if.source byte_out
);
	import vwtp_pkg::*;

	vwtp_cmd_t cmd;
	vwtp_sts_t sts;

	// capacity register is always writable
	assign cfg.ready = 1'b1;

	vwtp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (tok_in.valid),
		.in_ready (tok_in.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	vwtp_dp #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg.valid),
		.cfg_data    (cfg.dest_capacity),
		.token_value (tok_in.token_value),
		.token_width (tok_in.token_width),
		.out_valid   (byte_out.valid),
		.out_ready   (byte_out.ready),
		.out_byte    (byte_out.out_byte),
		.status      (byte_out.status),
		.last_of_run (byte_out.last_of_run)
	);

endmodule
